>>> hw/rtl/bpc_pkg.sv
// Package for the button press classifier: widths, register indexes, reset values,
// event codes and the threshold bundle shared by the top level and the button unit.
// Depends on nothing.
`default_nettype none

package bpc_pkg;

   // Width of each button's held-tick counter.
   localparam int COUNT_WIDTH = 16;
   localparam int THR_WIDTH   = 16;
   localparam int LVLCNT_WIDTH = 4;
   localparam int LEVEL_WIDTH = 3;
   // Width that holds both a counter value and a threshold without loss.
   localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_LONG_PRESS  = 2'd1,
      CSR_LEVEL_COUNT = 2'd2
   } csr_idx_type;

   localparam logic [THR_WIDTH-1:0]    DEBOUNCE_RESET    = THR_WIDTH'(5);
   localparam logic [THR_WIDTH-1:0]    LONG_PRESS_RESET  = THR_WIDTH'(300);
   localparam logic [LVLCNT_WIDTH-1:0] LEVEL_COUNT_RESET = LVLCNT_WIDTH'(4);
   localparam logic [LEVEL_WIDTH-1:0]  LEVEL_OFF         = '0;
   localparam logic [LEVEL_WIDTH-1:0]  LEVEL_TOP         = '1;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_ANYKEY = 2'd1,
      EV_SHORT  = 2'd2,
      EV_LONG   = 2'd3
   } ev_type;

   // Effective thresholds, already forced to at least one.
   typedef struct packed {
      logic [THR_WIDTH-1:0] debounce;
      logic [THR_WIDTH-1:0] long_press;
   } thr_type;

endpackage

`default_nettype wire

>>> hw/rtl/bpc_button.sv
// One button's press classifier: saturating held-tick counter plus the
// any-key-sent and long-sent flags. Depends on bpc_pkg.
`default_nettype none

module bpc_button (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic            down,
   input  wire logic            enabled,
   input  wire bpc_pkg::thr_type thr,
   output bpc_pkg::ev_type      evt
);
   import bpc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic                   anykey_ff, anykey_in;
   logic                   long_ff, long_in;
   logic                   stepped;
   logic [COUNT_WIDTH-1:0] hold_inc;
   logic [CMP_WIDTH-1:0]   hold_now, hold_old, deb_x, lng_x;

   always_comb begin
      stepped  = (hold_ff != COUNT_MAX);
      hold_inc = stepped ? hold_ff + COUNT_WIDTH'(1) : hold_ff;
      hold_now = CMP_WIDTH'(hold_inc);
      hold_old = CMP_WIDTH'(hold_ff);
      deb_x    = CMP_WIDTH'(thr.debounce);
      lng_x    = CMP_WIDTH'(thr.long_press);

      evt       = EV_NONE;
      hold_in   = hold_ff;
      anykey_in = anykey_ff;
      long_in   = long_ff;

      if (down) begin
         hold_in = hold_inc;
         // A saturated counter never re-reaches the debounce count.
         if (stepped && hold_now == deb_x && !enabled) begin
            evt       = EV_ANYKEY;
            anykey_in = 1'b1;
         end
         if (enabled && !long_ff && hold_now >= lng_x) begin
            evt     = EV_LONG;
            long_in = 1'b1;
         end
      end else begin
         if (hold_old >= deb_x && !long_ff) begin
            if (enabled) begin
               evt = (hold_old < lng_x) ? EV_SHORT : EV_LONG;
            end else if (!anykey_ff) begin
               evt = EV_ANYKEY;
            end
         end
         hold_in   = '0;
         anykey_in = 1'b0;
         long_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= '0;
         anykey_ff <= 1'b0;
         long_ff   <= 1'b0;
      end else if (step) begin
         hold_ff   <= hold_in;
         anykey_ff <= anykey_in;
         long_ff   <= long_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/button_press_classifier_core.sv
// Button press classifier top level: input word register, two button units,
// carbonation level update and the result word register. Depends on bpc_pkg
// and bpc_button.
// Pipeline: the input register, then the result register for the response word.
// Throughput: one word per cycle while the response side takes each word; the
// input register feeds the result register through one pass of compare and
// increment logic; button state updates as a word moves into the result register.
// Reset: synchronous, active high; clears counters, flags, the level and both
// valid bits, and loads the register reset values (debounce 5, long press 300,
// level count 4).
`default_nettype none

module button_press_classifier_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Bit 0 level_button_down, bit 1 filter_button_down, bit 2 buttons_enabled,
   // bits 7:3 zero.
   input  wire logic [bpc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Response channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Bits 1:0 level_event, bits 3:2 filter_event, bits 6:4 current_level,
   // bit 7 level_changed.
   output logic [bpc_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // Configuration write port.
   input  wire logic                                csr_we,
   input  wire logic [bpc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bpc_pkg::*;

   // Configuration registers.
   logic [THR_WIDTH-1:0]    debounce_ff;
   logic [THR_WIDTH-1:0]    long_press_ff;
   logic [LVLCNT_WIDTH-1:0] level_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
         level_count_ff <= LEVEL_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[THR_WIDTH-1:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_wdata[THR_WIDTH-1:0];
            CSR_LEVEL_COUNT: level_count_ff <= csr_wdata[LVLCNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // A threshold of zero behaves as one.
   thr_type thr;
   always_comb begin
      thr.debounce   = (debounce_ff == '0) ? THR_WIDTH'(1) : debounce_ff;
      thr.long_press = (long_press_ff == '0) ? THR_WIDTH'(1) : long_press_ff;
   end

   // Input stage. The stage moves forward whenever the result register is empty
   // or its word is being taken this cycle, so a stall at the response side only
   // holds the pipeline for as long as it lasts.
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_bits_ff;
   logic       advance;
   logic       rsp_valid_ff, rsp_valid_in;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_bits_ff <= req_tdata[2:0];
      end
   end

   logic lvl_down, flt_down, enabled;
   assign lvl_down = in_bits_ff[0];
   assign flt_down = in_bits_ff[1];
   assign enabled  = in_bits_ff[2];

   // Per-button classification; each unit commits its state on advance.
   ev_type lvl_ev, flt_ev;

   bpc_button u_level_button (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .down    (lvl_down),
      .enabled (enabled),
      .thr     (thr),
      .evt     (lvl_ev)
   );

   bpc_button u_filter_button (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .down    (flt_down),
      .enabled (enabled),
      .thr     (thr),
      .evt     (flt_ev)
   );

   // Carbonation level: a short press of the level button steps it up, and it
   // wraps to the off level at the configured count or past the top level.
   logic [LEVEL_WIDTH-1:0]  level_ff, level_in;
   logic [LVLCNT_WIDTH-1:0] level_next;

   always_comb begin
      level_next = LVLCNT_WIDTH'(level_ff) + LVLCNT_WIDTH'(1);
      level_in   = level_ff;
      if (lvl_ev == EV_SHORT) begin
         if (level_next >= level_count_ff || level_next > LVLCNT_WIDTH'(LEVEL_TOP)) begin
            level_in = LEVEL_OFF;
         end else begin
            level_in = level_next[LEVEL_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_OFF;
      end else if (advance) begin
         level_ff <= level_in;
      end
   end

   // Result register.
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {(level_in != level_ff), level_in, flt_ev, lvl_ev};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The level only moves on a short press of the level button.
   a_change_needs_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[1:0] == EV_SHORT)
      else $error("level changed without a short level press");

   // A word held in the input stage keeps its bits until it moves on.
   a_input_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_bits_ff))
      else $error("input stage word lost or changed while stalled");

   // The level only changes when a word moves forward; button state also commits only then.
   a_level_moves_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(level_ff))
      else $error("level changed without an advancing word");
`endif

endmodule

`default_nettype wire
